// File: hw/rtl/chirp_tone_envelope_generator_top_assert.svh
// Assertion macros for the chirp tone generator.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef CHIRP_TONE_ENVELOPE_GENERATOR_TOP_ASSERT_SVH
`define CHIRP_TONE_ENVELOPE_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CTG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chirp tone generator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chirp tone generator: next-cycle check failed");

`else

`define CTG_ASSERT_IMPLY(label, ante, cons)
`define CTG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/ctg_pkg.sv
// Shared types, constants and the sine table function of the chirp tone generator.
// No dependencies.
`default_nettype none

package ctg_pkg;

    // Default structural parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF      = 16;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 15;
    localparam int AMP_W     = 16;
    localparam int ENV_W     = 17;
    localparam int RAMP_W    = 25;
    localparam int CNT_CFG_W = 16;
    localparam int INC_W     = 32;
    localparam int PROD1_W   = MAG_W + AMP_W;
    localparam int PROD2_W   = PROD1_W + ENV_W;
    localparam int PROD_SHIFT = 31;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Envelope
    localparam int ENV_FRAC_BITS = 16;
    localparam int DIV_W         = 23;
    localparam logic [RAMP_W-1:0] U_ONE    = RAMP_W'(25'h100_0000);
    localparam logic [RAMP_W-1:0] ATTACK_U = RAMP_W'(1342177);
    localparam logic [RAMP_W-1:0] DECAY_AT = RAMP_W'(11744051);
    localparam logic [RAMP_W-1:0] DECAY_U  = RAMP_W'(5033165);
    localparam logic [ENV_W-1:0]  ENV_ONE  = ENV_W'(65536);

    // Sample saturation
    localparam logic [MAG_W-1:0] SAMPLE_MAX = MAG_W'(32767);

    // Sine table generation
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_SAMPLE_COUNT     = 3'd0,
        REG_FIRST_INCREMENT  = 3'd1,
        REG_INCREMENT_CHANGE = 3'd2,
        REG_AMPLITUDE        = 3'd3,
        REG_RAMP_STEP        = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_AMP,
        ST_AMP_WAIT,
        ST_FINISH
    } state_t;

    // Quarter-wave sine entry, Q2.30 Taylor series of degree 13, scaled to 32767.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned tab_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] r;
        x  = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        d  = ((x2 * t) >> 30) / 64'd156;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd110;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd72;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd42;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd20;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        d  = ((x2 * t) >> 30) / 64'd6;
        t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
        s  = (x * t) >> 30;
        r  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ctg_sine_rom.sv
// Quarter-wave sine ROM with registered read.
// Depends on ctg_pkg (sine_entry, MAG_W).
`default_nettype none

module ctg_sine_rom #(
    parameter int SINE_TABLE_BITS = ctg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [SINE_TABLE_BITS:0]   addr,
    output logic      [ctg_pkg::MAG_W-1:0]  data
);

    localparam int TAB_SIZE = 1 << SINE_TABLE_BITS;

    logic [ctg_pkg::MAG_W-1:0] rom_tab [0:TAB_SIZE];
    logic [ctg_pkg::MAG_W-1:0] data_reg;

    // Entries are fixed at elaboration
    for (genvar k = 0; k <= TAB_SIZE; k++)
    begin : g_entry
        assign rom_tab[k] = ctg_pkg::sine_entry(k, SINE_TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= rom_tab[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ctg_phase_acc.sv
// Bit-serial second-order phase accumulator: acc += step, step += change.
// Depends on ctg_pkg (INC_W).
`default_nettype none

module ctg_phase_acc #(
    parameter int PHASE_BITS = ctg_pkg::PHASE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [ctg_pkg::INC_W-1:0]   first_increment,
    input  wire logic                        advance,
    input  wire logic [ctg_pkg::INC_W-1:0]   increment_change,
    output logic      [PHASE_BITS-1:0]       acc,
    output logic                             busy
);

    localparam int CNT_W = $clog2(PHASE_BITS + 1);

    logic [PHASE_BITS-1:0] first_ext;
    logic [PHASE_BITS-1:0] change_ext;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] change_reg;
    logic                  carry_acc_reg;
    logic                  carry_step_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  sum_acc;
    logic                  sum_step;
    logic                  carry_acc_next;
    logic                  carry_step_next;

    // Sign-extend or truncate the 32-bit increments to the phase width
    if (PHASE_BITS > ctg_pkg::INC_W)
    begin : g_wide
        assign first_ext  = {{(PHASE_BITS - ctg_pkg::INC_W){first_increment[ctg_pkg::INC_W-1]}},
                             first_increment};
        assign change_ext = {{(PHASE_BITS - ctg_pkg::INC_W){increment_change[ctg_pkg::INC_W-1]}},
                             increment_change};
    end
    else if (PHASE_BITS == ctg_pkg::INC_W)
    begin : g_same
        assign first_ext  = first_increment;
        assign change_ext = increment_change;
    end
    else
    begin : g_narrow
        assign first_ext  = first_increment[PHASE_BITS-1:0];
        assign change_ext = increment_change[PHASE_BITS-1:0];
    end

    // One full-adder bit per word per cycle, LSB first
    always_comb
    begin
        sum_acc         = acc_reg[0] ^ step_reg[0] ^ carry_acc_reg;
        carry_acc_next  = (acc_reg[0] & step_reg[0]) | (carry_acc_reg & (acc_reg[0] ^ step_reg[0]));
        sum_step        = step_reg[0] ^ change_reg[0] ^ carry_step_reg;
        carry_step_next = (step_reg[0] & change_reg[0])
                        | (carry_step_reg & (step_reg[0] ^ change_reg[0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            carry_acc_reg  <= 1'b0;
            carry_step_reg <= 1'b0;
        end
        else if (load)
        begin
            acc_reg  <= '0;
            step_reg <= first_ext;
        end
        else if (advance)
        begin
            cnt_reg        <= CNT_W'(PHASE_BITS);
            carry_acc_reg  <= 1'b0;
            carry_step_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg        <= {sum_acc, acc_reg[PHASE_BITS-1:1]};
            step_reg       <= {sum_step, step_reg[PHASE_BITS-1:1]};
            carry_acc_reg  <= carry_acc_next;
            carry_step_reg <= carry_step_next;
            cnt_reg        <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            change_reg <= change_ext;
        end
        else if (cnt_reg != '0)
        begin
            change_reg <= {1'b0, change_reg[PHASE_BITS-1:1]};
        end
    end

    assign acc  = acc_reg;
    assign busy = (cnt_reg != '0);

endmodule

`default_nettype wire

// File: hw/rtl/ctg_env_div.sv
// Envelope from ramp position; restoring divider, one quotient bit per cycle.
// Depends on ctg_pkg (envelope constants and widths).
`default_nettype none

module ctg_env_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ctg_pkg::RAMP_W-1:0]   ramp,
    output logic                              busy,
    output logic      [ctg_pkg::ENV_W-1:0]    env
);

    localparam int CNT_W = $clog2(ctg_pkg::ENV_FRAC_BITS + 1);

    logic [ctg_pkg::DIV_W-1:0]         rem_reg;
    logic [ctg_pkg::DIV_W-1:0]         divisor_reg;
    logic [ctg_pkg::ENV_FRAC_BITS-1:0] quot_reg;
    logic                              full_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [ctg_pkg::DIV_W:0]           rem_shift;
    logic                              take;
    logic [ctg_pkg::RAMP_W-1:0]        decay_left;

    // Remainder always stays below the divisor, so the quotient fits in 16 bits
    always_comb
    begin
        rem_shift  = {rem_reg, 1'b0};
        take       = (rem_shift >= {1'b0, divisor_reg});
        decay_left = ctg_pkg::U_ONE - ramp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(ctg_pkg::ENV_FRAC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= '0;
            if (ramp < ctg_pkg::ATTACK_U)
            begin
                rem_reg     <= ramp[ctg_pkg::DIV_W-1:0];
                divisor_reg <= ctg_pkg::ATTACK_U[ctg_pkg::DIV_W-1:0];
                full_reg    <= 1'b0;
            end
            else if (ramp > ctg_pkg::DECAY_AT)
            begin
                rem_reg     <= decay_left[ctg_pkg::DIV_W-1:0];
                divisor_reg <= ctg_pkg::DECAY_U[ctg_pkg::DIV_W-1:0];
                full_reg    <= 1'b0;
            end
            else
            begin
                rem_reg     <= '0;
                divisor_reg <= ctg_pkg::DECAY_U[ctg_pkg::DIV_W-1:0];
                full_reg    <= 1'b1;
            end
        end
        else if (cnt_reg != '0)
        begin
            if (take)
            begin
                rem_reg <= rem_shift[ctg_pkg::DIV_W-1:0] - divisor_reg;
            end
            else
            begin
                rem_reg <= rem_shift[ctg_pkg::DIV_W-1:0];
            end
            quot_reg <= {quot_reg[ctg_pkg::ENV_FRAC_BITS-2:0], take};
        end
    end

    assign busy = (cnt_reg != '0);
    assign env  = full_reg ? ctg_pkg::ENV_ONE : {1'b0, quot_reg};

endmodule

`default_nettype wire

// File: hw/rtl/ctg_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, unsigned operands.
// No package dependencies.
`default_nettype none

module ctg_serial_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic                      busy,
    output logic      [A_W+B_W-1:0]   p
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] p_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [A_W:0]       upper_sum;

    // Add the multiplicand into the upper half when the low bit is set, then shift
    assign upper_sum = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= {upper_sum, p_reg[B_W-1:1]};
        end
    end

    assign busy = (cnt_reg != '0);
    assign p    = p_reg;

endmodule

`default_nettype wire

// File: hw/rtl/chirp_tone_envelope_generator_top.sv
// Top level of the swept-sine tone generator with attack/decay envelope.
// Depends on ctg_pkg, ctg_sine_rom, ctg_phase_acc, ctg_env_div, ctg_serial_mul
// and the assertion macros in chirp_tone_envelope_generator_top_assert.svh.
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ----------------------------
//  in        sink       in_valid/in_stall  start_req
//  out       source     out_valid/out_stall sample, last_sample, idle
//  cfg       APB slave  psel/penable/pready paddr, pwdata, prdata
//
// A playing sample passes through ST_LOAD, ST_AMP, ST_AMP_WAIT and ST_FINISH from input
// transfer to the output register: the bit-serial phase adder runs beside the shift-add
// multipliers, which run in turn, and a new tick is taken only once the block is back in
// ST_IDLE. A tick while idle goes straight to ST_FINISH and yields its silent result
// from there. Reset clears the tone state to idle; the sine ROM needs no clearing.
// A new tick is taken while the previous result still waits; it then holds on out_stall.
`default_nettype none

`include "chirp_tone_envelope_generator_top_assert.svh"

module chirp_tone_envelope_generator_top #(
    parameter int PHASE_BITS      = ctg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = ctg_pkg::SINE_TABLE_BITS_DEF,
    parameter int COUNT_BITS      = ctg_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input ticks
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              start_req,
    // output samples
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [ctg_pkg::SAMPLE_W-1:0]    sample,
    output logic                                   last_sample,
    output logic                                   idle,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ctg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ctg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ctg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ctg_pkg::CNT_CFG_W-1:0] sample_count_reg;
    logic [ctg_pkg::INC_W-1:0]     first_increment_reg;
    logic [ctg_pkg::INC_W-1:0]     increment_change_reg;
    logic [ctg_pkg::AMP_W-1:0]     amplitude_reg;
    logic [ctg_pkg::RAMP_W-1:0]    ramp_step_reg;
    logic                          cfg_write;
    ctg_pkg::cfg_idx_t             cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = ctg_pkg::cfg_idx_t'(paddr[ctg_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg     <= ctg_pkg::CNT_CFG_W'(1);
            first_increment_reg  <= '0;
            increment_change_reg <= '0;
            amplitude_reg        <= '0;
            ramp_step_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                ctg_pkg::REG_SAMPLE_COUNT:
                begin
                    sample_count_reg <= pwdata[ctg_pkg::CNT_CFG_W-1:0];
                end
                ctg_pkg::REG_FIRST_INCREMENT:
                begin
                    first_increment_reg <= pwdata[ctg_pkg::INC_W-1:0];
                end
                ctg_pkg::REG_INCREMENT_CHANGE:
                begin
                    increment_change_reg <= pwdata[ctg_pkg::INC_W-1:0];
                end
                ctg_pkg::REG_AMPLITUDE:
                begin
                    amplitude_reg <= pwdata[ctg_pkg::AMP_W-1:0];
                end
                ctg_pkg::REG_RAMP_STEP:
                begin
                    ramp_step_reg <= pwdata[ctg_pkg::RAMP_W-1:0];
                end
                default:
                begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    // Read back the addressed register, zero for unmapped addresses
    always_comb
    begin
        case (cfg_sel)
            ctg_pkg::REG_SAMPLE_COUNT:
            begin
                prdata = ctg_pkg::APB_DATA_W'(sample_count_reg);
            end
            ctg_pkg::REG_FIRST_INCREMENT:
            begin
                prdata = first_increment_reg;
            end
            ctg_pkg::REG_INCREMENT_CHANGE:
            begin
                prdata = increment_change_reg;
            end
            ctg_pkg::REG_AMPLITUDE:
            begin
                prdata = ctg_pkg::APB_DATA_W'(amplitude_reg);
            end
            ctg_pkg::REG_RAMP_STEP:
            begin
                prdata = ctg_pkg::APB_DATA_W'(ramp_step_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Tone state and control
    // ------------------------------------------------------------------
    ctg_pkg::state_t state_reg;
    ctg_pkg::state_t state_next;

    logic [COUNT_BITS-1:0]        index_reg;
    logic [ctg_pkg::RAMP_W-1:0]   ramp_reg;
    logic [ctg_pkg::RAMP_W-1:0]   ramp_next;
    logic [ctg_pkg::RAMP_W:0]     ramp_sum;
    logic                         playing_reg;
    logic                         silent_reg;
    logic                         last_reg;
    logic [1:0]                   quad_reg;

    logic [COUNT_BITS-1:0]        count_eff;
    logic [COUNT_BITS-1:0]        count_last;
    logic                         in_accept;
    logic                         out_free;

    logic                         phase_load;
    logic                         phase_adv;
    logic                         rom_rd;
    logic                         div_start;
    logic                         amp_start;
    logic                         env_start;
    logic                         out_write;

    logic                         phase_busy;
    logic                         div_busy;
    logic                         amp_busy;
    logic                         env_busy;

    logic [PHASE_BITS-1:0]                phase_acc;
    logic [SINE_TABLE_BITS-1:0]           tab_idx;
    logic [SINE_TABLE_BITS:0]             rom_addr;
    logic [ctg_pkg::MAG_W-1:0]            sine_mag;
    logic [ctg_pkg::ENV_W-1:0]            env_val;
    logic [ctg_pkg::PROD1_W-1:0]          amp_prod;
    logic [ctg_pkg::PROD2_W-1:0]          env_prod;
    logic [ctg_pkg::PROD2_W-ctg_pkg::PROD_SHIFT-1:0] prod_top;
    logic [ctg_pkg::MAG_W-1:0]            prod_sat;
    logic [ctg_pkg::SAMPLE_W-1:0]         sample_val;

    logic                                 out_valid_reg;
    logic [ctg_pkg::SAMPLE_W-1:0]         sample_reg;
    logic                                 last_out_reg;
    logic                                 idle_reg;

    assign in_stall  = (state_reg != ctg_pkg::ST_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    // Tone length masked to the index width; zero acts as one
    if (COUNT_BITS >= ctg_pkg::CNT_CFG_W)
    begin : g_count_wide
        assign count_eff = COUNT_BITS'(sample_count_reg);
    end
    else
    begin : g_count_narrow
        assign count_eff = sample_count_reg[COUNT_BITS-1:0];
    end

    assign count_last = (count_eff == '0) ? '0 : count_eff - 1'b1;

    // Ramp position saturates at u = 1
    assign ramp_sum  = {1'b0, ramp_reg} + {1'b0, ramp_step_reg};
    assign ramp_next = (ramp_sum > {1'b0, ctg_pkg::U_ONE}) ? ctg_pkg::U_ONE
                                                           : ramp_sum[ctg_pkg::RAMP_W-1:0];

    // Quadrant from the top two phase bits, mirror the index in odd quadrants
    assign tab_idx  = phase_acc[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_addr = phase_acc[PHASE_BITS-2]
                    ? ({1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, tab_idx})
                    : {1'b0, tab_idx};

    // Scale back by 2^31, saturate, and negate in the lower half cycle
    assign prod_top   = env_prod[ctg_pkg::PROD2_W-1:ctg_pkg::PROD_SHIFT];
    assign prod_sat   = (prod_top > {2'b00, ctg_pkg::SAMPLE_MAX}) ? ctg_pkg::SAMPLE_MAX
                                                                : prod_top[ctg_pkg::MAG_W-1:0];
    assign sample_val = quad_reg[1] ? (ctg_pkg::SAMPLE_W'(0) - {1'b0, prod_sat})
                                    : {1'b0, prod_sat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: load, read sine, amplitude then envelope products, emit; silent ticks just emit
    always_comb
    begin
        state_next = state_reg;
        phase_load = 1'b0;
        phase_adv  = 1'b0;
        rom_rd     = 1'b0;
        div_start  = 1'b0;
        amp_start  = 1'b0;
        env_start  = 1'b0;
        out_write  = 1'b0;
        case (state_reg)
            ctg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    phase_load = start_req;
                    state_next = (start_req | playing_reg) ? ctg_pkg::ST_LOAD
                                                           : ctg_pkg::ST_FINISH;
                end
            end
            ctg_pkg::ST_LOAD:
            begin
                // ROM samples the pre-update phase at this edge
                rom_rd     = 1'b1;
                div_start  = 1'b1;
                phase_adv  = 1'b1;
                state_next = ctg_pkg::ST_AMP;
            end
            ctg_pkg::ST_AMP:
            begin
                amp_start  = 1'b1;
                state_next = ctg_pkg::ST_AMP_WAIT;
            end
            ctg_pkg::ST_AMP_WAIT:
            begin
                if (!amp_busy && !div_busy)
                begin
                    env_start  = 1'b1;
                    state_next = ctg_pkg::ST_FINISH;
                end
            end
            ctg_pkg::ST_FINISH:
            begin
                if (!env_busy && !phase_busy && out_free)
                begin
                    out_write  = 1'b1;
                    state_next = ctg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctg_pkg::ST_IDLE;
            end
        endcase
    end

    // Tone state: restart on a start tick, advance when a sample is emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            ramp_reg    <= '0;
            playing_reg <= 1'b0;
            silent_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                silent_reg <= ~(start_req | playing_reg);
                if (start_req)
                begin
                    index_reg   <= '0;
                    ramp_reg    <= '0;
                    playing_reg <= 1'b1;
                end
            end
            else if (out_write && !silent_reg)
            begin
                index_reg <= index_reg + 1'b1;
                ramp_reg  <= ramp_next;
                if (last_reg)
                begin
                    playing_reg <= 1'b0;
                end
            end
        end
    end

    // Hold the per-sample flags taken before the phase moves on
    always_ff @(posedge clk)
    begin
        if (rom_rd)
        begin
            quad_reg <= phase_acc[PHASE_BITS-1 -: 2];
            last_reg <= (index_reg == count_last);
        end
    end

    // Output register parts the result from the next tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
        begin
            if (silent_reg)
            begin
                sample_reg   <= '0;
                last_out_reg <= 1'b0;
                idle_reg     <= 1'b1;
            end
            else
            begin
                sample_reg   <= sample_val;
                last_out_reg <= last_reg;
                idle_reg     <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_out_reg;
    assign idle        = idle_reg;

    // ------------------------------------------------------------------
    // Datapath units
    // ------------------------------------------------------------------
    ctg_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (phase_load),
        .first_increment  (first_increment_reg),
        .advance          (phase_adv),
        .increment_change (increment_change_reg),
        .acc              (phase_acc),
        .busy             (phase_busy)
    );

    ctg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (rom_rd),
        .addr  (rom_addr),
        .data  (sine_mag)
    );

    ctg_env_div u_env (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .ramp  (ramp_reg),
        .busy  (div_busy),
        .env   (env_val)
    );

    ctg_serial_mul #(
        .A_W (ctg_pkg::MAG_W),
        .B_W (ctg_pkg::AMP_W)
    ) u_mul_amp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (amp_start),
        .a     (sine_mag),
        .b     (amplitude_reg),
        .busy  (amp_busy),
        .p     (amp_prod)
    );

    ctg_serial_mul #(
        .A_W (ctg_pkg::PROD1_W),
        .B_W (ctg_pkg::ENV_W)
    ) u_mul_env (
        .clk   (clk),
        .rst_n (rst_n),
        .start (env_start),
        .a     (amp_prod),
        .b     (env_val),
        .busy  (env_busy),
        .p     (env_prod)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CTG_ASSERT_IMPLY(a_units_quiet_in_idle, state_reg == ctg_pkg::ST_IDLE, !phase_busy && !div_busy && !amp_busy && !env_busy)
    `CTG_ASSERT_NEXT(a_last_ends_tone, out_write && !silent_reg && last_reg && !in_accept, !playing_reg)
    `CTG_ASSERT_IMPLY(a_idle_is_silent, out_valid_reg && idle_reg, sample_reg == '0 && !last_out_reg)
    `CTG_ASSERT_IMPLY(a_ramp_bounded, 1'b1, ramp_reg <= ctg_pkg::U_ONE)

endmodule

`default_nettype wire

// File: verif/chirp_tone_envelope_generator_top_tb.sv
// Self-checking testbench for chirp_tone_envelope_generator_top: swept-sine tone
// samples are predicted per tick and checked against the block. Depends on ctg_pkg
// and the RTL of the block only.
module chirp_tone_envelope_generator_top_tb;

    import ctg_pkg::*;

    localparam int TAB_BITS       = 10;
    localparam int TAB_SIZE       = 1 << TAB_BITS;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 100;   // well past the sample latency
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
    localparam int RANDOM_ITEMS   = 950;   // random part stops here, the final part follows
    localparam int FINAL_TONES    = 6;
    localparam int FINAL_COUNT    = 25;

    // One expected output transfer.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pcm;
        logic                is_last;
        logic                is_idle;
    } tone_sample_t;

    // Tone scoreboard: keeps its own copy of the registers and the tone state,
    // computes the sample for every accepted tick and checks the block's output.
    class tone_tracker;
        logic [15:0]  cfg_count;
        logic [31:0]  cfg_first_inc;
        logic [31:0]  cfg_inc_change;
        logic [15:0]  cfg_amp;
        logic [24:0]  cfg_ramp_step;
        logic [15:0]  sample_idx;
        logic [31:0]  phase_acc;
        logic [31:0]  phase_inc;
        logic [24:0]  ramp_pos;
        bit           playing;
        logic [14:0]  quarter_sine [0:TAB_SIZE];
        tone_sample_t expected_samples [$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  starts;
        int unsigned  last_seen;
        int unsigned  silent_seen;

        function new();
            logic [63:0] divisors [6];
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] d;
            logic [63:0] s;
            logic [63:0] r;
            int unsigned k;
            int unsigned j;
            divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            // Quarter-wave table: Q2.30 Horner form of the Taylor series, scaled to 32767
            for (k = 0; k <= TAB_SIZE; k++)
            begin
                x  = (HALF_PI_Q30 * 64'(k)) >> TAB_BITS;
                x2 = (x * x) >> 30;
                t  = Q30_ONE;
                for (j = 0; j < 6; j++)
                begin
                    d = ((x2 * t) >> 30) / divisors[j];
                    t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
                end
                s = (x * t) >> 30;
                r = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
                if (r > 64'd32767)
                begin
                    r = 64'd32767;
                end
                quarter_sine[k] = r[14:0];
            end
            cfg_count      = 16'd1;
            cfg_first_inc  = '0;
            cfg_inc_change = '0;
            cfg_amp        = '0;
            cfg_ramp_step  = '0;
            sample_idx     = '0;
            phase_acc      = '0;
            phase_inc      = '0;
            ramp_pos       = '0;
            playing        = 1'b0;
            errors         = 0;
            checked        = 0;
            starts         = 0;
            last_seen      = 0;
            silent_seen    = 0;
        endfunction

        function void write_reg(cfg_idx_t r, logic [31:0] value);
            case (r)
                REG_SAMPLE_COUNT:     cfg_count      = value[15:0];
                REG_FIRST_INCREMENT:  cfg_first_inc  = value;
                REG_INCREMENT_CHANGE: cfg_inc_change = value;
                REG_AMPLITUDE:        cfg_amp        = value[15:0];
                REG_RAMP_STEP:        cfg_ramp_step  = value[24:0];
                default:              ;
            endcase
        endfunction

        // Attack/decay envelope in Q1.16, clamped to one.
        function logic [16:0] envelope(logic [24:0] u);
            logic [63:0] e;
            if (u < ATTACK_U)
                e = (64'(u) << 16) / 64'(ATTACK_U);
            else if (u > DECAY_AT)
                e = (64'(U_ONE - u) << 16) / 64'(DECAY_U);
            else
                e = 64'(ENV_ONE);
            if (e > 64'(ENV_ONE))
            begin
                e = 64'(ENV_ONE);
            end
            return e[16:0];
        endfunction

        // Note an accepted tick and queue the sample it must produce.
        function void note_tick(bit start);
            tone_sample_t exp_s;
            logic [1:0]   quad;
            logic [10:0]  tab_idx;
            logic [63:0]  prod;
            logic [15:0]  cnt;
            logic [31:0]  ramp_sum;
            if (start)
            begin
                sample_idx = '0;
                phase_acc  = '0;
                phase_inc  = cfg_first_inc;
                ramp_pos   = '0;
                playing    = 1'b1;
                starts++;
            end
            if (!playing)
            begin
                exp_s.pcm     = '0;
                exp_s.is_last = 1'b0;
                exp_s.is_idle = 1'b1;
            end
            else
            begin
                cnt           = (cfg_count == 16'd0) ? 16'd1 : cfg_count;
                exp_s.is_last = (sample_idx == cnt - 16'd1);
                exp_s.is_idle = 1'b0;
                // Mirror the table in odd quadrants, negate in the lower half cycle
                quad    = phase_acc[31:30];
                tab_idx = {1'b0, phase_acc[29:30-TAB_BITS]};
                if (quad[0])
                begin
                    tab_idx = 11'(TAB_SIZE) - tab_idx;
                end
                prod = (64'(quarter_sine[tab_idx]) * 64'(cfg_amp) * 64'(envelope(ramp_pos)))
                       >> 31;
                if (prod > 64'd32767)
                begin
                    prod = 64'd32767;
                end
                exp_s.pcm = quad[1] ? (16'd0 - prod[15:0]) : prod[15:0];
                // Advance the second-order phase, the ramp and the index
                phase_acc  = phase_acc + phase_inc;
                phase_inc  = phase_inc + cfg_inc_change;
                ramp_sum   = 32'(ramp_pos) + 32'(cfg_ramp_step);
                ramp_pos   = (ramp_sum > 32'(U_ONE)) ? U_ONE : ramp_sum[24:0];
                sample_idx = sample_idx + 16'd1;
                if (exp_s.is_last)
                begin
                    playing = 1'b0;
                end
            end
            expected_samples.push_back(exp_s);
        endfunction

        function void check_sample(logic [15:0] pcm, logic is_last, logic is_idle);
            tone_sample_t exp_s;
            if (expected_samples.size() == 0)
            begin
                errors++;
                $display("%0t: sample %0d last %b idle %b with no tick pending",
                         $time, $signed(pcm), is_last, is_idle);
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                checked++;
                if (exp_s.is_last)
                    last_seen++;
                if (exp_s.is_idle)
                    silent_seen++;
                if (pcm !== exp_s.pcm || is_last !== exp_s.is_last || is_idle !== exp_s.is_idle)
                begin
                    errors++;
                    $display("%0t: expected sample %0d last %b idle %b, got sample %0d last %b idle %b",
                             $time, $signed(exp_s.pcm), exp_s.is_last, exp_s.is_idle,
                             $signed(pcm), is_last, is_idle);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         start_req = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         last_sample;
    logic                         idle;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]        paddr = '0;
    logic [APB_DATA_W-1:0]        pwdata = '0;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;

    tone_tracker sb;
    bit          bursty = 1'b0;      // random idling on both channels
    bit          hold_req = 1'b0;    // ask the receiver for one long hold-off
    int unsigned items_sent = 0;
    int unsigned cfg_writes = 0;
    int unsigned quiet_cycles = 0;

    chirp_tone_envelope_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .idle        (idle),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = ~clk;
    end

    // Check every output transfer against the oldest queued sample.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            sb.check_sample(sample, last_sample, idle);
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                || (psel && penable))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                         $time, quiet_cycles, sb.pending());
                $display("[chirp_tone_envelope_generator_top] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: stall in random bursts, or hold off for one long stretch on request
    // so the block fills up and pushes back on the tick channel.
    initial
    begin : receiver
        int unsigned n;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (bursty && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // Offer one tick; hold it until the block takes the transfer. Valid stays high
    // afterwards so the next tick can follow back to back.
    task automatic send_tick(input bit start);
        int unsigned gap;
        @(negedge clk);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        start_req = start;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        sb.note_tick(start);
        items_sent++;
    endtask

    // Drop valid, wait for every queued sample, then let the pipeline drain.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB, then read it back and compare its bits.
    task automatic cfg_write(input cfg_idx_t r, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        case (r)
            REG_SAMPLE_COUNT, REG_AMPLITUDE: mask = 32'h0000_FFFF;
            REG_RAMP_STEP:                   mask = 32'h01FF_FFFF;
            default:                         mask = 32'hFFFF_FFFF;
        endcase
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {r, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.write_reg(r, value);
        // read-back: new setup phase right after the write access
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
        begin
            @(posedge clk);
        end
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        cfg_writes++;
        if ((got & mask) !== (value & mask))
        begin
            sb.errors++;
            $display("%0t: register %s expected %h, read back %h",
                     $time, r.name(), value & mask, got & mask);
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] count_val;
        logic [31:0] word;
        int unsigned pick;
        int unsigned phase_no;
        int unsigned tone_cnt;
        int unsigned len;
        int unsigned t;
        int unsigned k;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // Ticks straight out of reset: silent, idle, state untouched.
        send_tick(1'b0);
        send_tick(1'b0);
        drain();

        // Four samples, one per quadrant; full amplitude saturates on both signs,
        // the envelope goes from zero through one and back to zero.
        cfg_write(REG_SAMPLE_COUNT, 32'd4);
        cfg_write(REG_FIRST_INCREMENT, 32'h5000_0000);
        cfg_write(REG_INCREMENT_CHANGE, 32'd0);
        cfg_write(REG_AMPLITUDE, 32'h0000_FFFF);
        cfg_write(REG_RAMP_STEP, 32'd5592405);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain();

        // Zero count plays as a one-sample tone; the tick after it is idle.
        cfg_write(REG_SAMPLE_COUNT, 32'd0);
        cfg_write(REG_FIRST_INCREMENT, 32'h8000_0000);
        cfg_write(REG_INCREMENT_CHANGE, 32'h7FFF_FFFF);
        cfg_write(REG_AMPLITUDE, 32'd0);
        cfg_write(REG_RAMP_STEP, 32'h0100_0000);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // Ramp step above one: the ramp position must hold at one, not wrap.
        cfg_write(REG_SAMPLE_COUNT, 32'd3);
        cfg_write(REG_FIRST_INCREMENT, 32'h7FFF_FFFF);
        cfg_write(REG_INCREMENT_CHANGE, 32'h8000_0000);
        cfg_write(REG_AMPLITUDE, 32'h0000_8000);
        cfg_write(REG_RAMP_STEP, 32'h01FF_FFFF);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        drain();

        // Down-sweep across attack, flat top and decay, restarted mid-tone.
        cfg_write(REG_SAMPLE_COUNT, 32'd12);
        cfg_write(REG_FIRST_INCREMENT, 32'h0123_4567);
        cfg_write(REG_INCREMENT_CHANGE, 32'hFFF0_0000);
        cfg_write(REG_AMPLITUDE, 32'h0000_7FFF);
        cfg_write(REG_RAMP_STEP, 32'd1300000);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        repeat (11) send_tick(1'b0);
        drain();

        // ---- random part ----
        // Each setting is written while the block is drained; a tone left running
        // from the previous setting may carry on under the new one.
        bursty   = 1'b1;
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            drain();
            if (phase_no == 0 || $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    count_val = 16'd0;
                else if (pick == 1)
                    count_val = 16'd1;
                else if (pick == 2)
                    count_val = 16'hFFFF;
                else if (pick < 6)
                    count_val = 16'($urandom_range(41, 200));
                else
                    count_val = 16'($urandom_range(2, 40));
                cfg_write(REG_SAMPLE_COUNT, 32'(count_val));
            end
            if (phase_no == 0 || $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    word = 32'h8000_0000;
                else if (pick == 1)
                    word = 32'h7FFF_FFFF;
                else
                    word = $urandom;
                cfg_write(REG_FIRST_INCREMENT, word);
            end
            if (phase_no == 0 || $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 9);
                word = $urandom;
                if (pick == 0)
                    word = 32'h8000_0000;
                else if (pick == 1)
                    word = 32'h7FFF_FFFF;
                else if (pick == 2)
                    word = 32'd0;
                else if (pick > 4)
                    word = {{12{word[19]}}, word[19:0]};   // gentle sweep
                cfg_write(REG_INCREMENT_CHANGE, word);
            end
            if (phase_no == 0 || $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    word = 32'd0;
                else if (pick == 1)
                    word = 32'h0000_FFFF;
                else if (pick == 2)
                    word = 32'h0000_7FFF;
                else if (pick == 3)
                    word = 32'h0000_8000;
                else
                    word = 32'($urandom_range(0, 65535));
                cfg_write(REG_AMPLITUDE, word);
            end
            if (phase_no == 0 || $urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    word = 32'd0;
                else if (pick == 1)
                    word = 32'h0100_0000;
                else if (pick == 2)
                    word = 32'h01FF_FFFF;
                else if (pick == 3)
                    word = 32'($urandom) & 32'h01FF_FFFF;
                else
                begin
                    // roughly one over (count-1), with some jitter
                    len  = (sb.cfg_count > 16'd1) ? 32'(sb.cfg_count) - 1 : 1;
                    word = 32'h0100_0000 / len + 32'($urandom_range(0, 255));
                end
                cfg_write(REG_RAMP_STEP, word);
            end

            // One long hold-off on the output while ticks keep coming.
            if (phase_no == 1)
            begin
                hold_req = 1'b1;
                repeat (20) send_tick(1'b0);
            end

            tone_cnt = $urandom_range(1, 3);
            for (t = 0; t < tone_cnt; t++)
            begin
                // Sometimes carry on with the tone left running under the old setting.
                if (t != 0 || $urandom_range(0, 3) != 0)
                    send_tick(1'b1);
                len = (sb.cfg_count > 16'd1) ? 32'(sb.cfg_count) - 1 : 0;
                if (len > 60)
                    len = 60;
                for (k = 0; k < len; k++)
                begin
                    // rare restart mid-tone breaks the sequence
                    send_tick($urandom_range(0, 39) == 0);
                end
                // a little noise after the tone: idle ticks and stray starts
                len = $urandom_range(0, 2);
                for (k = 0; k < len; k++)
                begin
                    send_tick($urandom_range(0, 4) == 0);
                end
            end
            phase_no++;
        end

        // ---- final part: no idling on either side ----
        drain();
        bursty = 1'b0;
        cfg_write(REG_SAMPLE_COUNT, 32'(FINAL_COUNT));
        cfg_write(REG_FIRST_INCREMENT, $urandom);
        word = $urandom;
        cfg_write(REG_INCREMENT_CHANGE, {{14{word[17]}}, word[17:0]});
        cfg_write(REG_AMPLITUDE, 32'($urandom_range(0, 65535)));
        cfg_write(REG_RAMP_STEP, 32'h0100_0000 / (FINAL_COUNT - 1));
        repeat (FINAL_TONES)
        begin
            send_tick(1'b1);
            repeat (FINAL_COUNT - 1) send_tick(1'b0);
        end
        drain();

        $display("Run: %0d ticks, %0d tone starts, %0d samples checked (%0d final, %0d silent)",
                 items_sent, sb.starts, sb.checked, sb.last_seen, sb.silent_seen);
        $display("Run: %0d register writes over %0d settings, one %0d-cycle output hold-off",
                 cfg_writes, phase_no + 5, HOLD_CYCLES);
        if (sb.errors == 0)
        begin
            $display("[chirp_tone_envelope_generator_top] OK");
        end
        else
        begin
            $display("[chirp_tone_envelope_generator_top] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ctg_pkg.sv
hw/rtl/ctg_sine_rom.sv
hw/rtl/ctg_phase_acc.sv
hw/rtl/ctg_env_div.sv
hw/rtl/ctg_serial_mul.sv
hw/rtl/chirp_tone_envelope_generator_top.sv
verif/chirp_tone_envelope_generator_top_tb.sv
